@@ rtl/mbtcp_rd_pkg.sv @@
// Shared types and constants for the Modbus TCP response deframer.
// No dependencies; every other file in rtl imports this package.
package mbtcp_rd_pkg;

   localparam int unsigned HDR_BYTES = 7;
   localparam logic [2:0]  HDR_FILL_LAST = 3'd6;

   localparam logic [7:0]  FC_HOLDING = 8'h03;
   localparam logic [7:0]  FC_INPUT   = 8'h04;

   localparam logic [15:0] SENTINEL_LOW  = 16'd32765;
   localparam logic [15:0] SENTINEL_HIGH = 16'h7FFF;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLDING_BASE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INPUT_BASE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INPUT_ENABLE = 2'd2;

   localparam logic [15:0] HOLDING_BASE_RESET = 16'd1;
   localparam logic [15:0] INPUT_BASE_RESET   = 16'd21;
   localparam logic        INPUT_ENABLE_RESET = 1'b1;

   // Position inside a frame body: function code, byte count, then data.
   typedef enum logic [1:0] {
      STEP_CODE,
      STEP_COUNT,
      STEP_DATA
   } body_step_type;

   typedef struct packed {
      logic [15:0] holding_base;
      logic [15:0] input_base;
      logic        input_enable;
   } cfg_type;

   typedef struct packed {
      logic               is_input_register;
      logic [15:0]        register_number;
      logic signed [15:0] register_value;
      logic               value_valid;
      logic               last_of_frame;
   } result_type;

endpackage

@@ rtl/mbtcp_rd_csr.sv @@
// Configuration registers of the Modbus TCP response deframer.
// Depends on mbtcp_rd_pkg for register indexes and reset values.
module mbtcp_rd_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mbtcp_rd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [15:0]                               csr_data,
   output mbtcp_rd_pkg::cfg_type                     cfg
);
   import mbtcp_rd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HOLDING_BASE: cfg_in.holding_base = csr_data;
            CSR_INPUT_BASE:   cfg_in.input_base   = csr_data;
            CSR_INPUT_ENABLE: cfg_in.input_enable = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.holding_base <= HOLDING_BASE_RESET;
         cfg_ff.input_base   <= INPUT_BASE_RESET;
         cfg_ff.input_enable <= INPUT_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/mbtcp_rd_parser.sv @@
// Frame parser: header window, body tracking and register word assembly.
// Depends on mbtcp_rd_pkg; produces at most one result per accepted byte.
module mbtcp_rd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       kind,
   input  logic [7:0]                 byte_value,
   input  mbtcp_rd_pkg::cfg_type      cfg,
   output logic                       res_valid,
   output mbtcp_rd_pkg::result_type   res
);
   import mbtcp_rd_pkg::*;

   logic [7:0]    win_ff [HDR_BYTES];
   logic [7:0]    win_in [HDR_BYTES];
   logic [2:0]    fill_ff, fill_in;
   logic          in_body_ff, in_body_in;
   body_step_type step_ff, step_in;
   logic [15:0]   bytes_left_ff, bytes_left_in;
   logic [15:0]   payload_len_ff, payload_len_in;
   logic [7:0]    code_ff, code_in;
   logic [7:0]    count_ff, count_in;
   logic          accepted_ff, accepted_in;
   logic [7:0]    pos_ff, pos_in;
   logic [7:0]    hold_ff, hold_in;

   logic [15:0]   hdr_len;
   logic [15:0]   word;
   logic [6:0]    word_idx;
   logic          is_in;
   logic          fc_ok;

   assign hdr_len  = {win_ff[4], win_ff[5]};
   assign word     = {hold_ff, byte_value};
   assign word_idx = pos_ff[7:1];
   assign is_in    = (code_ff == FC_INPUT);
   assign fc_ok    = (code_ff == FC_HOLDING) || ((code_ff == FC_INPUT) && cfg.input_enable);

   always_comb begin
      win_in         = win_ff;
      fill_in        = fill_ff;
      in_body_in     = in_body_ff;
      step_in        = step_ff;
      bytes_left_in  = bytes_left_ff;
      payload_len_in = payload_len_ff;
      code_in        = code_ff;
      count_in       = count_ff;
      accepted_in    = accepted_ff;
      pos_in         = pos_ff;
      hold_in        = hold_ff;
      res_valid      = 1'b0;

      res.is_input_register = is_in;
      res.register_number   = (is_in ? cfg.input_base : cfg.holding_base) + {9'd0, word_idx};
      res.register_value    = word;
      res.value_valid       = !((word >= SENTINEL_LOW) && (word <= SENTINEL_HIGH));
      res.last_of_frame     = ({1'b0, word_idx} + 8'd1) == {1'b0, count_ff[7:1]};

      if (accept) begin
         if (kind) begin
            // new connection: drop header and any frame in progress
            fill_in    = '0;
            in_body_in = 1'b0;
            step_in    = STEP_CODE;
         end else if (!in_body_ff) begin
            win_in[fill_ff] = byte_value;
            if (fill_ff == HDR_FILL_LAST) begin
               if (hdr_len < 16'd2) begin
                  // drop the oldest byte and wait for one more
                  for (int i = 0; i < 5; i++) begin
                     win_in[i] = win_ff[i+1];
                  end
                  win_in[5] = byte_value;
                  win_in[6] = 8'h00;
                  fill_in   = HDR_FILL_LAST;
               end else begin
                  payload_len_in = hdr_len;
                  bytes_left_in  = hdr_len - 16'd1;
                  in_body_in     = 1'b1;
                  step_in        = STEP_CODE;
                  code_in        = '0;
                  count_in       = '0;
                  accepted_in    = 1'b0;
                  pos_in         = '0;
                  hold_in        = '0;
               end
            end else begin
               fill_in = fill_ff + 3'd1;
            end
         end else begin
            bytes_left_in = bytes_left_ff - 16'd1;
            unique case (step_ff)
               STEP_CODE: begin
                  code_in = byte_value;
                  step_in = STEP_COUNT;
               end
               STEP_COUNT: begin
                  count_in    = byte_value;
                  accepted_in = fc_ok && (payload_len_ff >= 16'd3) &&
                                ({1'b0, payload_len_ff} >= (17'd3 + {9'd0, byte_value}));
                  step_in     = STEP_DATA;
               end
               STEP_DATA: begin
                  if (accepted_ff && (pos_ff < count_ff)) begin
                     if (!pos_ff[0]) begin
                        hold_in = byte_value;
                     end else begin
                        res_valid = 1'b1;
                     end
                     pos_in = pos_ff + 8'd1;
                  end
               end
               default: step_in = STEP_CODE;
            endcase
            if (bytes_left_ff == 16'd1) begin
               in_body_in = 1'b0;
               fill_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         in_body_ff <= 1'b0;
         step_ff    <= STEP_CODE;
      end else begin
         fill_ff    <= fill_in;
         in_body_ff <= in_body_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff         <= win_in;
      bytes_left_ff  <= bytes_left_in;
      payload_len_ff <= payload_len_in;
      code_ff        <= code_in;
      count_ff       <= count_in;
      accepted_ff    <= accepted_in;
      pos_ff         <= pos_in;
      hold_ff        <= hold_in;
   end

endmodule

@@ rtl/mbtcp_rd_out_reg.sv @@
// Result register between the parser and the rsp_ channel.
// Depends on mbtcp_rd_pkg for the result struct.
module mbtcp_rd_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  mbtcp_rd_pkg::result_type   load_data,
   output logic                       space,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mbtcp_rd_pkg::result_type   out_data
);
   import mbtcp_rd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // take a new transaction when empty or whenever the held one leaves this cycle
   assign space     = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ rtl/modbus_tcp_response_deframer.sv @@
// Modbus TCP response deframer: takes one response byte per cycle on req_ and
// returns each complete register word of a function 3 or 4 frame on rsp_. A
// byte is accepted every cycle as long as the result register is empty or is
// being drained; the word completed by a byte appears on rsp_ in the cycle after
// that byte is accepted, held in a single output register. Configuration
// writes on csr_ are always taken and should be issued while no frame is open.
module modbus_tcp_response_deframer (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_kind,
   input  logic [7:0]                                req_byte_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_is_input_register,
   output logic [15:0]                               rsp_register_number,
   output logic signed [15:0]                        rsp_register_value,
   output logic                                      rsp_value_valid,
   output logic                                      rsp_last_of_frame,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mbtcp_rd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [15:0]                               csr_data
);
   import mbtcp_rd_pkg::*;

   cfg_type    cfg;
   result_type res;
   result_type rsp_data;
   logic       res_valid;
   logic       space;
   logic       accept;

   assign req_ready = space;
   assign accept    = req_valid && space;

   mbtcp_rd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbtcp_rd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_kind),
      .byte_value (req_byte_value),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   mbtcp_rd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_is_input_register = rsp_data.is_input_register;
   assign rsp_register_number   = rsp_data.register_number;
   assign rsp_register_value    = rsp_data.register_value;
   assign rsp_value_valid       = rsp_data.value_valid;
   assign rsp_last_of_frame     = rsp_data.last_of_frame;

endmodule

@@ sim/tb_modbus_tcp_response_deframer.sv @@
// Testbench for modbus_tcp_response_deframer: directed and random byte streams
// checked against an in-bench model of the frame parser.
// Depends on rtl/mbtcp_rd_pkg.sv and rtl/modbus_tcp_response_deframer.sv.
`timescale 1ns / 1ps

module tb_modbus_tcp_response_deframer;
   import mbtcp_rd_pkg::*;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   localparam int ID_FREE    = 0;
   localparam int ID_PID_LOW = 1;
   localparam int ID_ZERO    = 2;

   localparam int PHASE_ITEMS      = 300;
   localparam int LONG_HOLD_AFTER  = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int MAX_REPORTS      = 10;

   localparam result_type NO_WORD = '0;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       pinned;
      result_type word;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_kind = KIND_DATA;
   logic [7:0]        req_byte_value = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_is_input_register;
   logic [15:0]       rsp_register_number;
   logic signed [15:0] rsp_register_value;
   logic              rsp_value_valid;
   logic              rsp_last_of_frame;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_HOLDING_BASE;
   logic [15:0]       csr_data = 16'h0000;

   // Travels with each transaction so the monitor knows a typed-in result
   logic       row_pinned = 1'b0;
   result_type row_pin = '0;

   // Model state: register shadow and frame parser
   cfg_type     csr_shadow;
   logic [7:0]  hdr_win [0:HDR_BYTES-1];
   int          hdr_count;
   bit          body_open;
   int unsigned remaining;
   logic [15:0] frame_len;
   logic [7:0]  func_code;
   logic [7:0]  data_count;
   bit          take_words;
   logic [7:0]  data_pos;
   logic [7:0]  hi_byte;

   result_type  words_due [$];
   logic [7:0]  stream_bytes [$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          feed_quiet = 0;
   int          sink_quiet = 0;

   // Two short frames: a stray byte ahead of a holding frame, a clear, and an
   // input frame with an odd byte count.
   row_type plan [25] = '{
      '{KIND_DATA, 8'hC5, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h01, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h05, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h01, 1'b0, NO_WORD},
      '{KIND_DATA, FC_HOLDING, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h02, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h7F, 1'b0, NO_WORD},
      '{KIND_DATA, 8'hFF, 1'b1, '{1'b0, 16'd1, 16'sh7FFF, 1'b0, 1'b1}},
      '{KIND_CLEAR, 8'hA5, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h02, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h06, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h11, 1'b0, NO_WORD},
      '{KIND_DATA, FC_INPUT, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h03, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h80, 1'b0, NO_WORD},
      '{KIND_DATA, 8'h00, 1'b1, '{1'b1, 16'd21, 16'sh8000, 1'b1, 1'b1}},
      '{KIND_DATA, 8'h12, 1'b0, NO_WORD}
   };

   modbus_tcp_response_deframer DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_byte_value        (req_byte_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_is_input_register (rsp_is_input_register),
      .rsp_register_number   (rsp_register_number),
      .rsp_register_value    (rsp_register_value),
      .rsp_value_valid       (rsp_value_valid),
      .rsp_last_of_frame     (rsp_last_of_frame),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void drop_frame_state();
      int i;
      for (i = 0; i < HDR_BYTES; i++) hdr_win[i] = 8'h00;
      hdr_count  = 0;
      body_open  = 1'b0;
      remaining  = 0;
      frame_len  = 16'h0000;
      func_code  = 8'h00;
      data_count = 8'h00;
      take_words = 1'b0;
      data_pos   = 8'h00;
      hi_byte    = 8'h00;
   endfunction

   // Advance the parser by one transaction; return 1 when a word completes.
   function automatic bit deframe_byte(input logic kind, input logic [7:0] b,
                                       output result_type w);
      logic [15:0] len;
      logic [15:0] word;
      logic [15:0] base;
      int unsigned pos;
      int unsigned k;
      bit          is_in;
      bit          got;
      int          i;
      got = 1'b0;
      w = NO_WORD;
      if (kind == KIND_CLEAR) begin
         drop_frame_state();
         return 1'b0;
      end
      if (!body_open) begin
         if (hdr_count < HDR_BYTES) begin
            hdr_win[hdr_count] = b;
            hdr_count++;
         end
         if (hdr_count >= HDR_BYTES) begin
            len = {hdr_win[4], hdr_win[5]};
            if (len < 16'd2) begin
               // shift out the oldest byte and wait for another
               for (i = 0; i < HDR_BYTES - 1; i++) hdr_win[i] = hdr_win[i+1];
               hdr_win[HDR_BYTES-1] = 8'h00;
               hdr_count = HDR_BYTES - 1;
            end else begin
               frame_len  = len;
               remaining  = int'(len) - 1;
               body_open  = 1'b1;
               func_code  = 8'h00;
               data_count = 8'h00;
               take_words = 1'b0;
               data_pos   = 8'h00;
               hi_byte    = 8'h00;
            end
         end
         return 1'b0;
      end
      pos = 6 + int'(frame_len) - remaining;
      if (remaining > 0) remaining--;
      if (pos == 7) begin
         func_code = b;
      end else if (pos == 8) begin
         data_count = b;
         take_words = ((func_code == FC_HOLDING) ||
                       (func_code == FC_INPUT && csr_shadow.input_enable)) &&
                      int'(frame_len) >= 3 && int'(frame_len) >= 3 + int'(b);
      end else if (pos >= 9 && take_words && data_pos < data_count) begin
         if (!data_pos[0]) begin
            hi_byte = b;
         end else begin
            word  = {hi_byte, b};
            k     = int'(data_pos) >> 1;
            is_in = (func_code == FC_INPUT);
            base  = is_in ? csr_shadow.input_base : csr_shadow.holding_base;
            w.is_input_register = is_in;
            w.register_number   = base + 16'(k);
            w.register_value    = word;
            w.value_valid       = !(word >= SENTINEL_LOW && word <= SENTINEL_HIGH);
            w.last_of_frame     = ((k + 1) == (int'(data_count) >> 1));
            got = 1'b1;
         end
         data_pos++;
      end
      if (remaining == 0) begin
         body_open = 1'b0;
         hdr_count = 0;
      end
      return got;
   endfunction

   task automatic log_mismatch(input bit had_due, input result_type due, input result_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         if (!had_due)
            $display("%0t: unexpected word: in=%0d num=%0d val=%0d ok=%0d last=%0d", $realtime,
                     got.is_input_register, got.register_number, got.register_value,
                     got.value_valid, got.last_of_frame);
         else
            $display("%0t: word mismatch: expected in=%0d num=%0d val=%0d ok=%0d last=%0d, %s",
                     $realtime, due.is_input_register, due.register_number, due.register_value,
                     due.value_valid, due.last_of_frame,
                     $sformatf("actual in=%0d num=%0d val=%0d ok=%0d last=%0d",
                               got.is_input_register, got.register_number,
                               got.register_value, got.value_valid, got.last_of_frame));
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type got;
      result_type due;
      result_type w;
      if (reset) begin
         drop_frame_state();
         csr_shadow = '{HOLDING_BASE_RESET, INPUT_BASE_RESET, INPUT_ENABLE_RESET};
         words_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_is_input_register, rsp_register_number, rsp_register_value,
                    rsp_value_valid, rsp_last_of_frame};
            if (words_due.size() == 0) begin
               log_mismatch(1'b0, NO_WORD, got);
            end else begin
               due = words_due.pop_front();
               if (got.is_input_register !== due.is_input_register ||
                   got.register_number !== due.register_number ||
                   got.register_value !== due.register_value ||
                   got.value_valid !== due.value_valid ||
                   got.last_of_frame !== due.last_of_frame)
                  log_mismatch(1'b1, due, got);
            end
         end
         if (req_valid && req_ready) begin
            if (deframe_byte(req_kind, req_byte_value, w) && !row_pinned) words_due.push_back(w);
            if (row_pinned) words_due.push_back(row_pin);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HOLDING_BASE: csr_shadow.holding_base = csr_data;
               CSR_INPUT_BASE:   csr_shadow.input_base   = csr_data;
               CSR_INPUT_ENABLE: csr_shadow.input_enable = csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Draw a random wait, with occasional runs of back-to-back transactions.
   function automatic int draw_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 40);
      return $urandom_range(0, 15);
   endfunction

   task automatic offer(input logic kind, input logic [7:0] b, input logic pinned,
                        input result_type pin_word);
      int gap;
      gap = draw_wait(feed_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= b;
      row_pinned     <= pinned;
      row_pin        <= pin_word;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic flush_bytes(input int n);
      logic [7:0] b;
      repeat (n) begin
         if (stream_bytes.size() != 0) begin
            b = stream_bytes.pop_front();
            offer(KIND_DATA, b, 1'b0, NO_WORD);
         end
      end
   endtask

   // Queue one framed response; data words lean toward the sentinel range and extremes.
   task automatic build_frame(input logic [7:0] code, input int count, input int len,
                              input int ids);
      logic [15:0] tid;
      logic [15:0] pid;
      logic [15:0] len16;
      logic [15:0] word;
      int i;
      len16 = 16'(len);
      tid = (ids == ID_ZERO) ? 16'h0000 : 16'($urandom);
      pid = (ids == ID_ZERO) ? 16'h0000 :
            (ids == ID_PID_LOW) ? {8'($urandom), 8'h00} : 16'($urandom);
      word = 16'h0000;
      stream_bytes.push_back(tid[15:8]);
      stream_bytes.push_back(tid[7:0]);
      stream_bytes.push_back(pid[15:8]);
      stream_bytes.push_back(pid[7:0]);
      stream_bytes.push_back(len16[15:8]);
      stream_bytes.push_back(len16[7:0]);
      stream_bytes.push_back(8'($urandom));
      stream_bytes.push_back(code);
      if (len >= 3) stream_bytes.push_back(8'(count));
      for (i = 2; i <= len - 2; i++) begin
         if (i % 2 == 0) begin
            case ($urandom_range(0, 7))
               0: word = 16'($urandom_range(32763, 32767));
               1: word = ($urandom_range(0, 2) == 0) ? 16'h8000 :
                         ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
               default: word = 16'($urandom);
            endcase
            stream_bytes.push_back(word[15:8]);
         end else begin
            stream_bytes.push_back(word[7:0]);
         end
      end
   endtask

   task automatic put_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [15:0] hold_base, input logic [15:0] in_base,
                             input logic in_en);
      put_reg(CSR_SPARE, 16'($urandom));
      put_reg(CSR_HOLDING_BASE, hold_base);
      put_reg(CSR_INPUT_BASE, in_base);
      put_reg(CSR_INPUT_ENABLE, {15'($urandom), in_en});
      csr_valid <= 1'b0;
   endtask

   // Hold the input and wait until every expected word has been taken.
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_due.size() != 0) @(negedge clock);
      repeat (extra) @(posedge clock);
   endtask

   initial begin : result_sink
      int stall;
      int taken;
      taken = 0;
      wait (reset == 1'b0);
      forever begin
         // one long hold-off so the block fills and backs up its input
         if (taken == LONG_HOLD_AFTER) stall = LONG_HOLD_CYCLES;
         else stall = draw_wait(sink_quiet);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      int phase;
      int phase_end;
      int sel;
      int count;
      int len;
      logic [7:0] code;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) offer(plan[i].kind, plan[i].value, plan[i].pinned, plan[i].word);

      for (phase = 0; phase < 4; phase++) begin
         settle(4);
         case (phase)
            0: set_config(16'h0000, 16'hFFFF, 1'b0);
            1: set_config(16'hFFFF, 16'h0000, 1'b1);
            2: set_config(16'($urandom), 16'hFFFE, 1'b1);
            default: set_config(16'($urandom), 16'($urandom), 1'($urandom));
         endcase
         flush_bytes(stream_bytes.size());
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            sel   = $urandom_range(0, 19);
            code  = ($urandom_range(0, 4) < 3) ? FC_HOLDING : FC_INPUT;
            count = $urandom_range(0, 8) * 2 + (($urandom_range(0, 5) == 0) ? 1 : 0);
            if ($urandom_range(0, 79) == 0) count = $urandom_range(254, 255);
            len = 3 + count + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            if ($urandom_range(0, 49) == 0) len += $urandom_range(200, 300);
            case (sel)
               12, 13: begin
                  // framing intact, content rejected or random
                  case ($urandom_range(0, 3))
                     0: do code = 8'($urandom); while (code == FC_HOLDING || code == FC_INPUT);
                     1: len = 2;
                     2: len = 2 + count;
                     default: begin
                        code  = 8'($urandom_range(0, 7));
                        count = $urandom_range(0, 24);
                        len   = $urandom_range(2, 24);
                     end
                  endcase
                  build_frame(code, count, len, ID_FREE);
                  flush_bytes(stream_bytes.size());
               end
               14: begin
                  // stray byte ahead of a header, dropped by a short length
                  count = $urandom_range(0, 8) * 2;
                  offer(KIND_DATA, 8'($urandom), 1'b0, NO_WORD);
                  build_frame(code, count, 3 + count, ID_PID_LOW);
                  flush_bytes(stream_bytes.size());
               end
               15: begin
                  count = $urandom_range(0, 8) * 2;
                  repeat ($urandom_range(1, 6)) offer(KIND_DATA, 8'h00, 1'b0, NO_WORD);
                  build_frame(code, count, 3 + count, ID_ZERO);
                  flush_bytes(stream_bytes.size());
               end
               16: begin
                  // cut a frame short and start a new connection
                  build_frame(code, count, len, ID_FREE);
                  flush_bytes($urandom_range(1, stream_bytes.size() - 1));
                  stream_bytes.delete();
                  offer(KIND_CLEAR, 8'($urandom), 1'b0, NO_WORD);
               end
               17: begin
                  repeat ($urandom_range(1, 10)) offer(KIND_DATA, 8'($urandom), 1'b0, NO_WORD);
                  offer(KIND_CLEAR, 8'($urandom), 1'b0, NO_WORD);
               end
               18: offer(KIND_CLEAR, 8'($urandom), 1'b0, NO_WORD);
               default: begin
                  build_frame(code, count, len, ID_FREE);
                  flush_bytes(stream_bytes.size());
               end
            endcase
         end
         // leave a frame open across the next register writes
         build_frame(($urandom_range(0, 1) == 0) ? FC_HOLDING : FC_INPUT, 4, 7, ID_FREE);
         flush_bytes($urandom_range(1, 10));
      end
      flush_bytes(stream_bytes.size());

      settle(8);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
